/* design/mexp_pkg.sv */
// Shared constants and handshake types for the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

    // Width of one stream field on the ports.
    localparam int FIELD_W       = 32;
    // Width of the arithmetic; only the low bits of each field are used.
    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_W         = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

    localparam logic [OPERAND_WIDTH-1:0] ONE_W = {{(OPERAND_WIDTH-1){1'b0}}, 1'b1};

    // Request to the shared modular multiplier: product = x * y mod m, needs y < m.
    typedef struct packed {
        logic                     start;
        logic [OPERAND_WIDTH-1:0] x;
        logic [OPERAND_WIDTH-1:0] y;
        logic [OPERAND_WIDTH-1:0] m;
    } mexp_mul_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic [OPERAND_WIDTH-1:0] product;
    } mexp_mul_resp_t;

endpackage

/* design/mexp_modmul.sv */
// Bit-serial interleaved modular multiplier, one bit of x per cycle.
`timescale 1ns / 1ps

module mexp_modmul
    import mexp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  mexp_mul_req_t  req,
    output mexp_mul_resp_t resp
);

    localparam int W = OPERAND_WIDTH;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     x_reg, x_next;
    logic [W-1:0]     y_reg, y_next;
    logic [W-1:0]     m_reg, m_next;
    logic [W-1:0]     r_reg, r_next;

    logic [W-1:0]     addend;
    logic [W+1:0]     sum;
    logic [W+2:0]     diff1;
    logic [W+2:0]     diff2;
    logic [W-1:0]     r_step;

    // r = 2r + bit*y stays below 3m; fold it back with one of two subtracts.
    assign addend = x_reg[W-1] ? y_reg : '0;
    assign sum    = {1'b0, r_reg, 1'b0} + {2'b00, addend};
    assign diff1  = {1'b0, sum} - {3'b000, m_reg};
    assign diff2  = {1'b0, sum} - {2'b00, m_reg, 1'b0};

    always_comb
    begin
        if (!diff2[W+2])
        begin
            r_step = diff2[W-1:0];
        end
        else if (!diff1[W+2])
        begin
            r_step = diff1[W-1:0];
        end
        else
        begin
            r_step = sum[W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        if (busy_reg)
        begin
            r_next   = r_step;
            x_next   = {x_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = req.x;
            y_next    = req.y;
            m_next    = req.m;
            r_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign resp.busy    = busy_reg;
    assign resp.done    = done_reg;
    assign resp.product = r_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("multiplier done while still busy");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_partial_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (r_reg < m_reg))
        else $error("partial product not reduced below modulus");

endmodule

/* design/modular_exponentiation.sv */
// Top level: right-to-left binary modular exponentiation over a shared multiplier.
`timescale 1ns / 1ps

//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+-----------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: base, exponent, modulus
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: result; tuser: zero_modulus
//
//  Each item first reduces the base, then takes one multiply per set exponent bit and
//  one square per exponent bit below the highest set bit, all on the single
//  bit-serial modular multiplier. A zero modulus or zero exponent skips the multiplier.
//  Reset clears the sequencer and the output valid; nothing needs a clearing pass.
//  The input is ready only while the sequencer is idle; a finished result waits in
//  the output register, and the next item may be accepted meanwhile.

module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // s_axis_tdata, low bit up: base, exponent, modulus
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [3*FIELD_W-1:0] s_axis_tdata,
    // m_axis_tdata: result; m_axis_tuser: zero_modulus
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [FIELD_W-1:0]   m_axis_tdata,
    output logic                 m_axis_tuser
);

    localparam int W = OPERAND_WIDTH;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_SQR    = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [W-1:0]       out_data_reg, out_data_next;
    logic               out_zm_reg, out_zm_next;
    logic [W-1:0]       base_reg, base_next;
    logic [W-1:0]       exp_reg, exp_next;
    logic [W-1:0]       mod_reg, mod_next;
    logic [W-1:0]       acc_reg, acc_next;
    logic               zm_reg, zm_next;

    logic [W-1:0]       in_base;
    logic [W-1:0]       in_exp;
    logic [W-1:0]       in_mod;
    logic [W-1:0]       one_mod;
    logic [W-1:0]       exp_shift;
    logic               accept;
    logic               out_load;
    mexp_mul_req_t      mul_req;
    mexp_mul_resp_t     mul_resp;

    // Use only the low operand bits of each field.
    assign in_base = s_axis_tdata[W-1:0];
    assign in_exp  = s_axis_tdata[FIELD_W+W-1:FIELD_W];
    assign in_mod  = s_axis_tdata[2*FIELD_W+W-1:2*FIELD_W];

    // 1 mod m; multiplying the raw base by it reduces the base.
    assign one_mod = (in_mod == ONE_W) ? '0 : ONE_W;

    assign exp_shift     = exp_reg >> 1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        exp_next    = exp_reg;
        mod_next    = mod_reg;
        acc_next    = acc_reg;
        zm_next     = zm_reg;
        mul_req.start = 1'b0;
        mul_req.x     = acc_reg;
        mul_req.y     = base_reg;
        mul_req.m     = mod_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mod_next = in_mod;
                    exp_next = in_exp;
                    zm_next  = (in_mod == '0);
                    if (in_mod == '0)
                    begin
                        // Zero modulus wins over everything, zero exponent included.
                        acc_next   = '0;
                        state_next = ST_FIN;
                    end
                    else if (in_exp == '0)
                    begin
                        // Zero exponent returns 1 unreduced.
                        acc_next   = ONE_W;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        acc_next      = ONE_W;
                        mul_req.start = 1'b1;
                        mul_req.x     = in_base;
                        mul_req.y     = one_mod;
                        mul_req.m     = in_mod;
                        state_next    = ST_REDUCE;
                    end
                end
            end

            ST_REDUCE:
            begin
                if (mul_resp.done)
                begin
                    base_next     = mul_resp.product;
                    mul_req.start = 1'b1;
                    if (exp_reg[0])
                    begin
                        mul_req.x  = acc_reg;
                        mul_req.y  = mul_resp.product;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        mul_req.x  = mul_resp.product;
                        mul_req.y  = mul_resp.product;
                        state_next = ST_SQR;
                    end
                end
            end

            ST_MUL:
            begin
                if (mul_resp.done)
                begin
                    acc_next = mul_resp.product;
                    // Skip squares once no higher exponent bit is left.
                    if (exp_shift != '0)
                    begin
                        mul_req.start = 1'b1;
                        mul_req.x     = base_reg;
                        mul_req.y     = base_reg;
                        state_next    = ST_SQR;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_SQR:
            begin
                if (mul_resp.done)
                begin
                    base_next     = mul_resp.product;
                    exp_next      = exp_shift;
                    mul_req.start = 1'b1;
                    if (exp_shift[0])
                    begin
                        mul_req.x  = acc_reg;
                        mul_req.y  = mul_resp.product;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        mul_req.x  = mul_resp.product;
                        mul_req.y  = mul_resp.product;
                        state_next = ST_SQR;
                    end
                end
            end

            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load on finish, drop once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_zm_next    = out_zm_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = acc_reg;
            out_zm_next    = zm_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    mexp_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .resp  (mul_resp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        exp_reg      <= exp_next;
        mod_reg      <= mod_next;
        acc_reg      <= acc_next;
        zm_reg       <= zm_next;
        out_data_reg <= out_data_next;
        out_zm_reg   <= out_zm_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = FIELD_W'(out_data_reg);
    assign m_axis_tuser  = out_zm_reg;

    a_zero_mod_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero modulus flagged with nonzero result");

    a_zero_mod_path: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_mod == '0)) |=> ((state_reg == ST_FIN) && zm_reg))
        else $error("zero modulus did not go straight to finish");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_resp.done |-> ((state_reg == ST_REDUCE) || (state_reg == ST_MUL)
                           || (state_reg == ST_SQR)))
        else $error("multiplier result arrived with no step waiting");

endmodule

/* tb/modular_exponentiation_test.sv */
// Self-checking testbench for the modular exponentiation stream block.
`timescale 1ns / 1ps

module modular_exponentiation_test;
    import mexp_pkg::*;

    // Worst-case bound for one item: base reduction plus a multiply per exponent bit
    // and a square per bit below the top one, each a full pass of the bit-serial
    // multiplier, plus the finish state.
    localparam int LATENCY_MAX    = 2 * OPERAND_WIDTH * (OPERAND_WIDTH + 1) + 2;
    localparam int DIRECTED_COUNT = 24;
    localparam int RANDOM_COUNT   = 266;
    localparam int MAX_GAP        = 2500;   // longest sender gap between bursts
    localparam int MAX_STALL      = 3000;   // longest receiver stall in its pattern
    localparam int LONG_HOLD      = 6000;   // one-off receiver hold-off, > 2 items
    localparam int CYCLE_LIMIT    = 3 * (DIRECTED_COUNT + RANDOM_COUNT)
                                    * (LATENCY_MAX + MAX_GAP + MAX_STALL)
                                    + LONG_HOLD + 10000;

    typedef struct packed {
        logic [FIELD_W-1:0] result;
        logic               zero_modulus;
    } power_result_t;

    // One directed row; known marks rows whose answer is typed in by hand.
    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
        logic               known;
        logic [FIELD_W-1:0] result;
        logic               zero_modulus;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // zero modulus wins over everything, zero exponent included
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        // zero exponent returns 1 unreduced, even for a modulus of 1
        '{32'h0000_0005, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0001, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0007, 1'b1, 32'h0000_0001, 1'b0},
        // trivial bases and moduli
        '{32'h0000_0000, 32'h0000_0001, 32'h0000_0007, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0000_0002, 32'h0000_000A, 32'h0000_03E8, 1'b1, 32'h0000_0018, 1'b0},
        '{32'h0000_0003, 32'h0000_0001, 32'h0000_0005, 1'b1, 32'h0000_0003, 1'b0},
        // unreduced base: base at or above modulus; then m-1 squared and 2 to the 31st
        '{32'h0000_0007, 32'h0000_0001, 32'h0000_0005, 1'b1, 32'h0000_0002, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFE, 32'h0000_0002, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 1'b0},
        '{32'h0000_0002, 32'h0000_001F, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0},
        // small textbook key pair: encrypt then decrypt
        '{32'd65,        32'd17,        32'd3233,      1'b1, 32'd2790,      1'b0},
        '{32'd2790,      32'd2753,      32'd3233,      1'b1, 32'd65,        1'b0},
        // wide operands, checked against the predictor
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'h0, 1'b0},
        '{32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0, 32'h0, 1'b0},
        '{32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{32'h1234_5678, 32'h9ABC_DEF0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0002, 32'h8000_0001, 1'b0, 32'h0, 1'b0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_AAAB, 1'b0, 32'h0, 1'b0}
    };

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [3*FIELD_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [FIELD_W-1:0]   m_axis_tdata;
    logic                 m_axis_tuser;

    power_result_t awaited_powers [$];   // predicted results, oldest first
    int            error_count      = 0;
    int            cycle_count      = 0;
    bit            hold_off_request = 1'b0;
    bit            receiver_holding = 1'b0;

    modular_exponentiation uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hold reset from time zero, release it on a falling edge, never assert it again.
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Right-to-left square and multiply on the low OPERAND_WIDTH bits, products at
    // double width so nothing overflows.
    function automatic power_result_t power_mod(input logic [FIELD_W-1:0] base,
                                                input logic [FIELD_W-1:0] exponent,
                                                input logic [FIELD_W-1:0] modulus);
        logic [OPERAND_WIDTH-1:0]   e;
        logic [OPERAND_WIDTH-1:0]   m;
        logic [2*OPERAND_WIDTH-1:0] m_wide;
        logic [2*OPERAND_WIDTH-1:0] acc;
        logic [2*OPERAND_WIDTH-1:0] pw;
        power_result_t              r;
        int                         k;
        e = exponent[OPERAND_WIDTH-1:0];
        m = modulus[OPERAND_WIDTH-1:0];
        m_wide = (2*OPERAND_WIDTH)'(m);
        r.result       = '0;
        r.zero_modulus = 1'b0;
        if (m == '0)
        begin
            r.zero_modulus = 1'b1;
        end
        else if (e == '0)
        begin
            r.result = 1;
        end
        else
        begin
            acc = (2*OPERAND_WIDTH)'(1);
            pw  = (2*OPERAND_WIDTH)'(base[OPERAND_WIDTH-1:0]) % m_wide;
            for (k = 0; k < OPERAND_WIDTH; k++)
            begin
                if (e[k])
                    acc = (acc * pw) % m_wide;
                pw = (pw * pw) % m_wide;
            end
            r.result = FIELD_W'(acc);
        end
        return r;
    endfunction

    // Present one item from the current falling edge, hold it until accepted, then
    // queue its expected result and advance to the next falling edge.
    task automatic offer_item(input logic [FIELD_W-1:0] base,
                              input logic [FIELD_W-1:0] exponent,
                              input logic [FIELD_W-1:0] modulus,
                              input power_result_t      want);
        s_axis_tdata  <= {modulus, exponent, base};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        awaited_powers.push_back(want);
        @(negedge clk);
    endtask

    task automatic idle_sender(input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop valid and wait for every outstanding result to come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (awaited_powers.size() != 0)
            @(negedge clk);
    endtask

    // Mostly well-formed operands with short exponents; a few full-width exponents
    // keep every exponent bit toggling without making the run slow.
    task automatic pick_operands(output logic [FIELD_W-1:0] base,
                                 output logic [FIELD_W-1:0] exponent,
                                 output logic [FIELD_W-1:0] modulus);
        int sel;
        int len;
        sel = $urandom_range(0, 15);
        case (sel)
            0:       modulus = '0;
            1:       modulus = 1;
            2:       modulus = '1;
            3:       modulus = 32'h1 << $urandom_range(1, 31);
            4, 5:    modulus = $urandom_range(2, 255);
            6:       modulus = $urandom_range(2, 65535);
            default: modulus = $urandom;
        endcase
        sel = $urandom_range(0, 99);
        if (sel < 5)
        begin
            exponent = '0;
        end
        else if (sel < 15)
        begin
            exponent     = $urandom;
            exponent[31] = 1'b1;
        end
        else
        begin
            len              = (sel < 80) ? $urandom_range(1, 8) : $urandom_range(9, 31);
            exponent         = $urandom & ((32'h1 << len) - 1);
            exponent[len-1]  = 1'b1;
        end
        sel = $urandom_range(0, 9);
        case (sel)
            0:       base = '0;
            1:       base = 1;
            2:       base = modulus - 1;
            3:       base = modulus + $urandom_range(0, 1000);
            4:       base = '1 - $urandom_range(0, 3);
            default: base = $urandom;
        endcase
    endtask

    // Sender: directed table first, then random bursts.
    initial
    begin : stimulus
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
        power_result_t      want;
        int                 sent;
        int                 burst;
        bit                 paused_once;

        sent        = 0;
        paused_once = 1'b0;
        @(posedge rst_n);
        @(negedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            if (DIRECTED_ROWS[i].known)
            begin
                want.result       = DIRECTED_ROWS[i].result;
                want.zero_modulus = DIRECTED_ROWS[i].zero_modulus;
            end
            else
            begin
                want = power_mod(DIRECTED_ROWS[i].base, DIRECTED_ROWS[i].exponent,
                                 DIRECTED_ROWS[i].modulus);
            end
            offer_item(DIRECTED_ROWS[i].base, DIRECTED_ROWS[i].exponent,
                       DIRECTED_ROWS[i].modulus, want);
            idle_sender($urandom_range(0, 3));
        end

        // Let everything drain, then ask the receiver for its long hold-off while
        // the sender keeps offering back to back, so the block backs up.
        drain_results();
        hold_off_request = 1'b1;

        while (sent < RANDOM_COUNT)
        begin
            burst = $urandom_range(1, 6);
            repeat (burst)
            begin
                if (sent < RANDOM_COUNT)
                begin
                    pick_operands(base, exponent, modulus);
                    offer_item(base, exponent, modulus, power_mod(base, exponent, modulus));
                    sent++;
                end
            end
            if (!paused_once && sent >= RANDOM_COUNT / 2)
            begin
                // pause the sender until every result is back
                drain_results();
                paused_once = 1'b1;
            end
            else if (!receiver_holding && !hold_off_request)
            begin
                idle_sender(($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP)
                                                        : $urandom_range(0, 20));
            end
        end

        drain_results();
        repeat (LATENCY_MAX) @(posedge clk);
        if (error_count == 0)
            $display("modular_exponentiation test passed");
        else
            $display("modular_exponentiation test failed");
        $finish;
    end

    // Receiver: stretches of always-ready, random and sparse ready, plus stalls; one
    // long hold-off on request from the sender.
    initial
    begin : receiver
        int mode;
        int span;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                receiver_holding = 1'b1;
                hold_off_request = 1'b0;
                m_axis_tready   <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                receiver_holding = 1'b0;
            end
            mode = $urandom_range(0, 7);
            span = (mode == 7) ? $urandom_range(400, MAX_STALL) : $urandom_range(20, 400);
            repeat (span)
            begin
                case (mode)
                    0, 1, 2: m_axis_tready <= 1'b1;
                    3, 4:    m_axis_tready <= 1'($urandom_range(0, 1));
                    5:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= 1'b0;
                endcase
                @(negedge clk);
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        power_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_powers.size() == 0)
            begin
                $error("unexpected result item: result %h zero_modulus %b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = awaited_powers.pop_front();
                if (m_axis_tdata !== want.result)
                begin
                    $error("result mismatch: expected %h, actual %h",
                           want.result, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== want.zero_modulus)
                begin
                    $error("zero_modulus mismatch: expected %b, actual %b",
                           want.zero_modulus, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("modular_exponentiation test failed");
            $finish;
        end
    end

endmodule
